### hdl/sarc_pkg.sv
// ----------------------------------------------------------------------------
// sarc_pkg
// Shared constants and types for the slot allocator with reference counts.
// ----------------------------------------------------------------------------
package sarc_pkg;

  localparam int SLOTS_DEFAULT    = 1024;
  localparam int REF_BITS_DEFAULT = 16;

  // fixed field widths of the stream words
  localparam int FUNC_W  = 3;
  localparam int SLOT_W  = 10;
  localparam int LIMIT_W = 11;
  localparam int STAT_W  = 3;
  localparam int REFS_W  = 16;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

  // operation codes
  localparam logic [FUNC_W-1:0] FN_ALLOC  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_FREE   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_LOOKUP = 3'd2;
  localparam logic [FUNC_W-1:0] FN_UNREF  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_RETIRE = 3'd4;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 3'd1;
  localparam logic [STAT_W-1:0] ST_DEAD  = 3'd2;
  localparam logic [STAT_W-1:0] ST_BUSY  = 3'd3;
  localparam logic [STAT_W-1:0] ST_UNDER = 3'd4;
  localparam logic [STAT_W-1:0] ST_OVER  = 3'd5;

  // update controls from the execute logic to the state holders
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              tbl_we;
    logic              push;
    logic              pop;
    logic              live_inc;
    logic              live_dec;
  } sarc_ctl_t;

endpackage

### hdl/sarc_ram.sv
// ----------------------------------------------------------------------------
// sarc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sarc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/sarc_exec.sv
// ----------------------------------------------------------------------------
// sarc_exec
// Modify step: decides one operation from the slot entry and free-stack word
// read when the word was accepted, and produces the write-back and result.
// ----------------------------------------------------------------------------
module sarc_exec #(
  parameter int SLOTS    = sarc_pkg::SLOTS_DEFAULT,
  parameter int REF_BITS = sarc_pkg::REF_BITS_DEFAULT
) (
  input  logic [sarc_pkg::FUNC_W-1:0]  func,
  input  logic [sarc_pkg::SLOT_W-1:0]  slot,
  input  logic [REF_BITS+1:0]          entry,     // {live, refable, count}
  input  logic [$clog2(SLOTS)-1:0]     fs_data,
  input  logic [$clog2(SLOTS+1)-1:0]   free_top,
  input  logic [$clog2(SLOTS+1)-1:0]   live_count,
  input  logic [sarc_pkg::LIMIT_W-1:0] slot_limit,
  output sarc_pkg::sarc_ctl_t          ctl,
  output logic [$clog2(SLOTS)-1:0]     addr,
  output logic [REF_BITS+1:0]          wdata,
  output logic [sarc_pkg::SLOT_W-1:0]  slot_out,
  output logic [REF_BITS-1:0]          refs
);

  localparam int SIDX = $clog2(SLOTS);

  logic [31:0]         lim;
  logic                in_range;
  logic                live;
  logic                refable;
  logic [REF_BITS-1:0] cnt;

  assign live     = entry[REF_BITS+1];
  assign refable  = entry[REF_BITS];
  assign cnt      = entry[REF_BITS-1:0];
  assign in_range = 32'(slot) < 32'(SLOTS);
  assign lim      = (32'(slot_limit) < 32'(SLOTS)) ? 32'(slot_limit) : 32'(SLOTS);

  always_comb begin
    ctl        = '0;
    ctl.status = sarc_pkg::ST_OK;
    addr       = SIDX'(slot);
    wdata      = entry;
    slot_out   = slot;
    refs       = '0;
    if (func == sarc_pkg::FN_ALLOC) begin
      if (32'(live_count) >= lim) begin
        ctl.status = sarc_pkg::ST_FULL;
        slot_out   = '0;
      end else begin
        // reuse the most recently freed slot, else the next fresh one
        addr         = (free_top != '0) ? fs_data : SIDX'(live_count);
        ctl.pop      = (free_top != '0);
        ctl.live_inc = 1'b1;
        ctl.tbl_we   = 1'b1;
        wdata        = {1'b1, 1'b1, {REF_BITS{1'b0}}};
        slot_out     = sarc_pkg::SLOT_W'(addr);
      end
    end else if (func > sarc_pkg::FN_RETIRE || !in_range || !live) begin
      ctl.status = sarc_pkg::ST_DEAD;
    end else begin
      refs = cnt;
      case (func)
        sarc_pkg::FN_FREE: begin
          if (cnt != '0) begin
            ctl.status = sarc_pkg::ST_BUSY;
          end else begin
            ctl.tbl_we   = 1'b1;
            wdata        = '0;
            ctl.push     = (32'(free_top) < 32'(SLOTS));
            ctl.live_dec = (live_count != '0);
          end
        end
        sarc_pkg::FN_LOOKUP: begin
          if (!refable) begin
            ctl.status = sarc_pkg::ST_DEAD;
          end else if (cnt == {REF_BITS{1'b1}}) begin
            ctl.status = sarc_pkg::ST_OVER;
          end else begin
            refs       = cnt + REF_BITS'(1);
            ctl.tbl_we = 1'b1;
            wdata      = {live, refable, refs};
          end
        end
        sarc_pkg::FN_UNREF: begin
          if (cnt == '0) begin
            ctl.status = sarc_pkg::ST_UNDER;
          end else begin
            refs       = cnt - REF_BITS'(1);
            ctl.tbl_we = 1'b1;
            wdata      = {live, refable, refs};
          end
        end
        default: begin
          // retire
          ctl.tbl_we = 1'b1;
          wdata      = {live, 1'b0, cnt};
        end
      endcase
    end
  end

endmodule

### hdl/slot_allocator_with_refcounts_unit.sv
// ----------------------------------------------------------------------------
// slot_allocator_with_refcounts_unit
// Slot table with LIFO free stack and per-slot reference counts.
// ----------------------------------------------------------------------------
// Each input word is handled in ST_IDLE and then ST_EXEC: the cycle in which
// it is accepted reads the slot-table RAM and the free-stack RAM, then ST_EXEC modifies
// the entry, writes it back and loads the result register. One word is in
// work at a time, so reads never overlap a pending write. A new word can be
// accepted while the previous result still waits on the output side; the
// write-back step holds only while the result register is occupied. After
// reset, s_axis_tready stays low while the slot table is cleared one entry
// per cycle; slot_limit writes are taken at any time.
module slot_allocator_with_refcounts_unit #(
  parameter int SLOTS    = sarc_pkg::SLOTS_DEFAULT,
  parameter int REF_BITS = sarc_pkg::REF_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // func[2:0], slot[12:3], zero[15:13]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // status[2:0], slot_out[12:3],
                                      // live_total[23:13], refs_out[39:24]
  input  logic        cfg_we,
  input  logic [10:0] cfg_data        // slot_limit
);

  localparam int SIDX = $clog2(SLOTS);
  localparam int LW   = $clog2(SLOTS + 1);
  localparam int EW   = REF_BITS + 2;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  state_t state, state_next;

  logic [sarc_pkg::LIMIT_W-1:0] slot_limit;
  logic [LW-1:0]                free_top;
  logic [LW-1:0]                live_count;
  logic [LW-1:0]                live_next;
  logic [SIDX-1:0]              clr_idx;
  logic [sarc_pkg::FUNC_W-1:0]  req_func;
  logic [sarc_pkg::SLOT_W-1:0]  req_slot;

  logic                         accept;
  logic                         advance;
  logic                         fire;

  logic [EW-1:0]                tbl_rdata;
  logic [EW-1:0]                tbl_wdata;
  logic [SIDX-1:0]              tbl_waddr;
  logic                         tbl_we;
  logic [SIDX-1:0]              fs_rdata;

  sarc_pkg::sarc_ctl_t          ctl;
  logic [SIDX-1:0]              x_addr;
  logic [EW-1:0]                x_wdata;
  logic [sarc_pkg::SLOT_W-1:0]  x_slot;
  logic [REF_BITS-1:0]          x_refs;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign fire          = (state == ST_EXEC) && advance;

  // clearing pass owns the table write port after reset
  assign tbl_we    = (state == ST_CLEAR) || (fire && ctl.tbl_we);
  assign tbl_waddr = (state == ST_CLEAR) ? clr_idx : x_addr;
  assign tbl_wdata = (state == ST_CLEAR) ? '0 : x_wdata;

  sarc_ram #(
    .WIDTH(EW),
    .DEPTH(SLOTS)
  ) u_tbl (
    .clk  (clk),
    .we   (tbl_we),
    .waddr(tbl_waddr),
    .wdata(tbl_wdata),
    .re   (accept),
    .raddr(SIDX'(s_axis_tdata[12:3])),
    .rdata(tbl_rdata)
  );

  sarc_ram #(
    .WIDTH(SIDX),
    .DEPTH(SLOTS)
  ) u_fstk (
    .clk  (clk),
    .we   (fire && ctl.push),
    .waddr(SIDX'(free_top)),
    .wdata(x_addr),
    .re   (accept),
    .raddr(SIDX'(free_top - LW'(1))),
    .rdata(fs_rdata)
  );

  sarc_exec #(
    .SLOTS   (SLOTS),
    .REF_BITS(REF_BITS)
  ) u_exec (
    .func      (req_func),
    .slot      (req_slot),
    .entry     (tbl_rdata),
    .fs_data   (fs_rdata),
    .free_top  (free_top),
    .live_count(live_count),
    .slot_limit(slot_limit),
    .ctl       (ctl),
    .addr      (x_addr),
    .wdata     (x_wdata),
    .slot_out  (x_slot),
    .refs      (x_refs)
  );

  always_comb begin
    live_next = live_count;
    if (ctl.live_inc) begin
      live_next = live_count + LW'(1);
    end else if (ctl.live_dec) begin
      live_next = live_count - LW'(1);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_idx == SIDX'(SLOTS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (advance) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_idx       <= '0;
      slot_limit    <= sarc_pkg::LIMIT_RESET;
      free_top      <= '0;
      live_count    <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + SIDX'(1);
      end
      if (cfg_we) begin
        slot_limit <= cfg_data;
      end
      if (fire) begin
        live_count <= live_next;
        if (ctl.pop) begin
          free_top <= free_top - LW'(1);
        end else if (ctl.push) begin
          free_top <= free_top + LW'(1);
        end
      end
      if (fire) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_func <= s_axis_tdata[2:0];
      req_slot <= s_axis_tdata[12:3];
    end
    if (fire) begin
      m_axis_tdata <= {sarc_pkg::REFS_W'(x_refs), sarc_pkg::LIMIT_W'(live_next),
                       x_slot, ctl.status};
    end
  end

  // one word in work at a time
  assert property (@(posedge clk) disable iff (rst) accept |=> !s_axis_tready)
    else $error("word accepted while previous one in work");

  // live slots and free-stack entries together never exceed the table size
  assert property (@(posedge clk) disable iff (rst)
    (32'(free_top) + 32'(live_count)) <= 32'(SLOTS))
    else $error("free stack and live count exceed table size");

  // the write-back always hands a result to the output register
  assert property (@(posedge clk) disable iff (rst) fire |=> m_axis_tvalid)
    else $error("result lost after write-back");

  // no operation runs during the clearing pass
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |=> (live_count == '0 && free_top == '0))
    else $error("state changed during clearing pass");

endmodule

### tb/slot_allocator_with_refcounts_unit_tb.sv
// ----------------------------------------------------------------------------
// slot_allocator_with_refcounts_unit_tb
// Self-checking bench for the slot allocator: a ledger class tracks slot
// liveness, reference counts and the LIFO free stack, and predicts every
// result word. Directed corner cases come first, then random traffic under
// several slot limits, a full-table fill and a short reference-count run.
// ----------------------------------------------------------------------------
module slot_allocator_with_refcounts_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT       = sarc_pkg::SLOTS_DEFAULT;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam logic [sarc_pkg::REFS_W-1:0] REFS_MAX = '1;

  typedef struct {
    logic [sarc_pkg::STAT_W-1:0]  status;
    logic [sarc_pkg::SLOT_W-1:0]  slot;
    logic [sarc_pkg::LIMIT_W-1:0] live;
    logic [sarc_pkg::REFS_W-1:0]  refs;
  } slot_reply_t;

  // Tracks the slot table and holds the replies still owed by the block.
  class slot_ledger;
    int unsigned                 limit;
    int unsigned                 live_cnt;
    int unsigned                 stack_top;
    logic [sarc_pkg::SLOT_W-1:0] free_stack [NSLOT];
    bit                          is_live [NSLOT];
    bit                          refable [NSLOT];
    logic [sarc_pkg::REFS_W-1:0] refcnt [NSLOT];
    logic [sarc_pkg::SLOT_W-1:0] last_slot;
    slot_reply_t                 owed [$];
    int unsigned                 mismatches;

    function new();
      limit = sarc_pkg::LIMIT_RESET;
      live_cnt = 0;
      stack_top = 0;
      mismatches = 0;
      last_slot = '0;
      foreach (is_live[i]) begin
        is_live[i] = 1'b0;
        refable[i] = 1'b0;
        refcnt[i] = '0;
        free_stack[i] = '0;
      end
    endfunction

    function int unsigned pending();
      return owed.size();
    endfunction

    function logic [sarc_pkg::SLOT_W-1:0] pick_live();
      int unsigned k;
      k = $urandom_range(NSLOT - 1);
      for (int n = 0; n < NSLOT; n++) begin
        if (is_live[(k + n) % NSLOT]) return sarc_pkg::SLOT_W'((k + n) % NSLOT);
      end
      return sarc_pkg::SLOT_W'(k);
    endfunction

    function void apply_request(logic [sarc_pkg::FUNC_W-1:0] fn,
                                logic [sarc_pkg::SLOT_W-1:0] idx);
      slot_reply_t r;
      int unsigned cap;
      r.status = sarc_pkg::ST_OK;
      r.slot = idx;
      r.refs = '0;
      if (fn == sarc_pkg::FN_ALLOC) begin
        cap = (limit < NSLOT) ? limit : NSLOT;
        if (live_cnt >= cap) begin
          r.status = sarc_pkg::ST_FULL;
          r.slot = '0;
        end else begin
          if (stack_top > 0) begin
            stack_top--;
            r.slot = free_stack[stack_top];
          end else begin
            r.slot = sarc_pkg::SLOT_W'(live_cnt);
          end
          live_cnt++;
          is_live[r.slot] = 1'b1;
          refable[r.slot] = 1'b1;
          refcnt[r.slot] = '0;
        end
      end else if (fn > sarc_pkg::FN_RETIRE || !is_live[idx]) begin
        r.status = sarc_pkg::ST_DEAD;
      end else begin
        r.refs = refcnt[idx];
        case (fn)
          sarc_pkg::FN_FREE: begin
            if (r.refs != 0) begin
              r.status = sarc_pkg::ST_BUSY;
            end else begin
              is_live[idx] = 1'b0;
              refable[idx] = 1'b0;
              if (stack_top < NSLOT) begin
                free_stack[stack_top] = idx;
                stack_top++;
              end
              if (live_cnt > 0) live_cnt--;
            end
          end
          sarc_pkg::FN_LOOKUP: begin
            if (!refable[idx]) r.status = sarc_pkg::ST_DEAD;
            else if (r.refs == REFS_MAX) r.status = sarc_pkg::ST_OVER;
            else begin
              r.refs++;
              refcnt[idx] = r.refs;
            end
          end
          sarc_pkg::FN_UNREF: begin
            if (r.refs == 0) r.status = sarc_pkg::ST_UNDER;
            else begin
              r.refs--;
              refcnt[idx] = r.refs;
            end
          end
          default: refable[idx] = 1'b0;
        endcase
      end
      r.live = sarc_pkg::LIMIT_W'(live_cnt);
      last_slot = r.slot;
      owed.push_back(r);
    endfunction

    function void match_reply(slot_reply_t got);
      slot_reply_t want;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: status %0d slot %0d live %0d refs %0d",
                   got.status, got.slot, got.live, got.refs);
        return;
      end
      want = owed.pop_front();
      if (got.status !== want.status || got.slot !== want.slot ||
          got.live !== want.live || got.refs !== want.refs) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected status %0d slot %0d live %0d refs %0d,",
                   want.status, want.slot, want.live, want.refs,
                   " got status %0d slot %0d live %0d refs %0d",
                   got.status, got.slot, got.live, got.refs);
      end
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [15:0]                  s_axis_tdata = '0;  // func[2:0], slot[12:3], zero[15:13]
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [39:0]                  m_axis_tdata;       // status[2:0], slot_out[12:3],
                                                    // live_total[23:13], refs_out[39:24]
  logic                         cfg_we = 1'b0;
  logic [sarc_pkg::LIMIT_W-1:0] cfg_data = '0;

  slot_ledger  ledger = new();
  bit          quiet = 1'b0;   // no idling on either side while set
  int unsigned cycle_count = 0;

  slot_allocator_with_refcounts_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("slot_allocator_with_refcounts_unit verification failed");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_cycles();
    int unsigned roll;
    if (quiet) return 0;
    roll = $urandom_range(99);
    if (roll < 75) return $urandom_range(3, 1);
    if (roll < 95) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  // result side: random back-pressure, checks every accepted word
  initial begin
    int unsigned hold;
    slot_reply_t got;
    hold = 0;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = m_axis_tdata[2:0];
        got.slot   = m_axis_tdata[12:3];
        got.live   = m_axis_tdata[23:13];
        got.refs   = m_axis_tdata[39:24];
        ledger.match_reply(got);
      end
      if (hold > 0 && !quiet) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        hold = ($urandom_range(99) < 30) ? gap_cycles() : 0;
      end
    end
  end

  // called at a rising edge; returns at the edge the word was taken, or after a random idle gap behind it
  task automatic send_word(input logic [sarc_pkg::FUNC_W-1:0] fn,
                           input logic [sarc_pkg::SLOT_W-1:0] idx);
    int unsigned gap;
    s_axis_tdata  <= {3'b000, idx, fn};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    ledger.apply_request(fn, idx);
    gap = ($urandom_range(99) < 30) ? gap_cycles() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (ledger.pending() != 0);
  endtask

  task automatic write_limit(input logic [sarc_pkg::LIMIT_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    ledger.limit = value;
  endtask

  task automatic random_traffic(input int unsigned count);
    int unsigned roll;
    logic [sarc_pkg::FUNC_W-1:0] fn;
    logic [sarc_pkg::SLOT_W-1:0] idx;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 50 == 0) quiet = ($urandom_range(99) < 25);
      roll = $urandom_range(99);
      if (roll < 25) fn = sarc_pkg::FN_ALLOC;
      else if (roll < 40) fn = sarc_pkg::FN_FREE;
      else if (roll < 65) fn = sarc_pkg::FN_LOOKUP;
      else if (roll < 85) fn = sarc_pkg::FN_UNREF;
      else if (roll < 94) fn = sarc_pkg::FN_RETIRE;
      else fn = sarc_pkg::FUNC_W'($urandom_range(7, 5));
      // mostly address live slots so lookups and frees get past the checks
      if (ledger.live_cnt > 0 && $urandom_range(99) < 85) idx = ledger.pick_live();
      else idx = sarc_pkg::SLOT_W'($urandom);
      send_word(fn, idx);
    end
    quiet = 1'b0;
  endtask

  initial begin
    logic [sarc_pkg::SLOT_W-1:0] victim;
    logic [sarc_pkg::SLOT_W-1:0] hot;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed corner cases at the reset limit
    send_word(sarc_pkg::FN_ALLOC, 10'd0);
    send_word(sarc_pkg::FN_ALLOC, 10'd0);
    send_word(sarc_pkg::FN_LOOKUP, 10'd0);
    send_word(sarc_pkg::FN_UNREF, 10'd0);
    send_word(sarc_pkg::FN_UNREF, 10'd0);      // underflow
    send_word(sarc_pkg::FN_FREE, 10'd0);
    send_word(sarc_pkg::FN_FREE, 10'd0);       // already free
    send_word(sarc_pkg::FN_ALLOC, 10'd0);      // reuses the freed slot
    send_word(sarc_pkg::FN_LOOKUP, 10'd1);
    send_word(sarc_pkg::FN_FREE, 10'd1);       // busy
    send_word(sarc_pkg::FN_RETIRE, 10'd1);
    send_word(sarc_pkg::FN_LOOKUP, 10'd1);     // retired slot
    send_word(sarc_pkg::FN_UNREF, 10'd1);
    send_word(sarc_pkg::FN_FREE, 10'd1);       // retired slot may still be freed
    send_word(sarc_pkg::FN_UNREF, 10'd1023);
    send_word(sarc_pkg::FN_RETIRE, 10'd1023);
    send_word(sarc_pkg::FN_LOOKUP, 10'd1023);
    send_word(3'd5, 10'd1023);
    send_word(3'd6, 10'd0);
    send_word(3'd7, 10'd682);
    send_word(sarc_pkg::FN_ALLOC, 10'd1023);   // slot field ignored
    send_word(sarc_pkg::FN_FREE, 10'd0);
    drain_results();

    // zero limit: every allocate is refused
    write_limit(11'd0);
    send_word(sarc_pkg::FN_ALLOC, 10'd0);
    send_word(sarc_pkg::FN_ALLOC, 10'd341);
    send_word(sarc_pkg::FN_LOOKUP, 10'd1);
    drain_results();

    write_limit(11'd1);
    random_traffic(50);
    drain_results();

    write_limit(11'd12);
    random_traffic(60);
    drain_results();

    write_limit(sarc_pkg::LIMIT_W'($urandom_range(64, 2)));
    random_traffic(50);
    drain_results();

    // limit above the table size: fill every slot, then run near full
    write_limit(11'd2047);
    while (ledger.live_cnt < NSLOT) send_word(sarc_pkg::FN_ALLOC, sarc_pkg::SLOT_W'($urandom));
    send_word(sarc_pkg::FN_ALLOC, 10'd0);
    send_word(sarc_pkg::FN_ALLOC, 10'd1023);
    random_traffic(40);
    drain_results();

    write_limit(11'd1024);
    random_traffic(40);
    drain_results();

    // short reference-count run on a freshly allocated slot
    quiet = 1'b1;
    if (ledger.live_cnt >= NSLOT) begin
      victim = ledger.pick_live();
      while (ledger.refcnt[victim] != 0) send_word(sarc_pkg::FN_UNREF, victim);
      send_word(sarc_pkg::FN_FREE, victim);
    end
    send_word(sarc_pkg::FN_ALLOC, 10'd0);
    hot = ledger.last_slot;
    repeat (4) send_word(sarc_pkg::FN_LOOKUP, hot);
    send_word(sarc_pkg::FN_UNREF, hot);
    send_word(sarc_pkg::FN_FREE, hot);         // busy
    send_word(sarc_pkg::FN_RETIRE, hot);
    send_word(sarc_pkg::FN_LOOKUP, hot);       // retired slot
    send_word(sarc_pkg::FN_UNREF, hot);
    drain_results();
    quiet = 1'b0;

    repeat (20) @(posedge clk);
    if (ledger.mismatches == 0 && ledger.pending() == 0) begin
      $display("slot_allocator_with_refcounts_unit verification clean");
    end else begin
      $display("slot_allocator_with_refcounts_unit verification failed");
    end
    $finish;
  end

endmodule
